>>> design/lfu_pkg.sv
// Package for the LFU oldest-slot replacement block.
// Holds shared types and constants; depends on nothing.
package lfu_pkg;

   localparam int unsigned VOTE_BITS  = 16;
   localparam int unsigned STAMP_BITS = 32;
   localparam int unsigned CFG_BITS   = 6;
   localparam int unsigned MAX_LIST   = 32;

   localparam logic CMD_RECOMMEND = 1'b0;
   localparam logic CMD_LIST      = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start_rec;   // capture candidate, clear scan
      logic scan_step;   // visit one slot in the recommend scan
      logic commit_rec;  // apply hit/insert/evict and form answer
      logic start_list;  // begin a listing pass
      logic list_step;   // visit one slot in the list minimum search
      logic emit_list;   // form a list result from the found minimum
      logic rsp_take;    // output word was taken
   } lfu_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;   // scan visited the last slot
      logic list_found;  // the list search found a candidate
      logic list_more;   // listing may continue after this entry
   } lfu_sts_type;

endpackage

>>> design/lfu_datapath.sv
// Datapath of the LFU block: slot storage, serial scans and result register.
// Depends on lfu_pkg.
module lfu_datapath
   import lfu_pkg::*;
#(
   parameter int unsigned SLOTS   = 32,
   parameter int unsigned ID_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  lfu_cmd_type         cmd,
   output lfu_sts_type         sts,
   input  logic [ID_BITS-1:0]  cand,
   input  logic [CFG_BITS-1:0] frames,
   output logic                out_kind,
   output logic                out_present,
   output logic                out_evf,
   output logic [ID_BITS-1:0]  out_evid,
   output logic [4:0]          out_slot,
   output logic [ID_BITS-1:0]  out_lid,
   output logic [VOTE_BITS-1:0] out_lvotes,
   output logic                out_valid,
   output logic                out_last
);
   localparam int unsigned SB = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned OB = $clog2(SLOTS + 1);
   localparam logic [SB-1:0] LAST_SLOT = SB'(SLOTS - 1);

   logic [ID_BITS-1:0]    ids_ff   [SLOTS];
   logic [VOTE_BITS-1:0]  votes_ff [SLOTS];
   logic [STAMP_BITS-1:0] stamp_ff [SLOTS];
   logic [SLOTS-1:0]      used_ff;
   logic [OB-1:0]         occ_ff;
   logic [STAMP_BITS-1:0] seq_ff;

   logic [ID_BITS-1:0] cand_ff;
   logic [SB-1:0]      idx_ff;
   logic               hit_ff, free_ff, pick_ff;
   logic [SB-1:0]      hit_slot_ff, free_slot_ff, pick_slot_ff;
   logic [VOTE_BITS-1:0]  pick_votes_ff;
   logic [STAMP_BITS-1:0] pick_stamp_ff;

   // listing: emit ids greater than prev in ascending order
   logic               have_prev_ff;
   logic [ID_BITS-1:0] prev_ff;
   logic [5:0]         nlist_ff;
   logic               lfound_ff;
   logic [SB-1:0]      lslot_ff;
   // number of held ids still to be listed, counted during each pass
   logic [OB-1:0]      rem_ff;

   // clamped limit
   logic [OB-1:0] limit;
   always_comb begin
      if (frames == '0) limit = OB'(1);
      else if (7'(frames) > 7'(SLOTS)) limit = OB'(SLOTS);
      else limit = OB'(frames);
   end

   logic              cur_used;
   logic [ID_BITS-1:0] cur_id;
   logic [VOTE_BITS-1:0] cur_votes;
   logic [STAMP_BITS-1:0] cur_stamp;
   assign cur_used  = used_ff[idx_ff];
   assign cur_id    = ids_ff[idx_ff];
   assign cur_votes = votes_ff[idx_ff];
   assign cur_stamp = stamp_ff[idx_ff];

   logic better;
   assign better = !pick_ff || (cur_votes < pick_votes_ff) ||
                   (cur_votes == pick_votes_ff && cur_stamp < pick_stamp_ff);

   logic lahead;
   assign lahead = cur_used && (!have_prev_ff || cur_id > prev_ff);

   logic lbetter;
   assign lbetter = lahead && (!lfound_ff || cur_id < ids_ff[lslot_ff]);

   assign sts.scan_done  = (idx_ff == LAST_SLOT);
   assign sts.list_found = lfound_ff;
   assign sts.list_more  = (rem_ff > OB'(1)) && (nlist_ff != 6'(MAX_LIST - 1));

   logic use_free;
   logic [SB-1:0] tgt;
   assign use_free = free_ff && (occ_ff < limit);
   assign tgt = use_free ? free_slot_ff : pick_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         occ_ff   <= '0;
         seq_ff   <= '0;
         out_kind <= 1'b0;
      end else begin
         if (cmd.start_rec || cmd.start_list) begin
            idx_ff    <= '0;
            hit_ff    <= 1'b0;
            free_ff   <= 1'b0;
            pick_ff   <= 1'b0;
            lfound_ff <= 1'b0;
         end
         if (cmd.start_rec) cand_ff <= cand;
         if (cmd.start_list) begin
            have_prev_ff <= 1'b0;
            nlist_ff     <= '0;
            rem_ff       <= '0;
         end
         if (cmd.scan_step) begin
            idx_ff <= idx_ff + SB'(1);
            if (cur_used && cur_id == cand_ff && !hit_ff) begin
               hit_ff <= 1'b1; hit_slot_ff <= idx_ff;
            end
            if (!cur_used && !free_ff) begin
               free_ff <= 1'b1; free_slot_ff <= idx_ff;
            end
            if (cur_used && better) begin
               pick_ff <= 1'b1; pick_slot_ff <= idx_ff;
               pick_votes_ff <= cur_votes; pick_stamp_ff <= cur_stamp;
            end
         end
         if (cmd.list_step) begin
            idx_ff <= idx_ff + SB'(1);
            if (lahead) rem_ff <= rem_ff + OB'(1);
            if (lbetter) begin
               lfound_ff <= 1'b1; lslot_ff <= idx_ff;
            end
         end
         if (cmd.commit_rec) begin
            if (seq_ff != '1) seq_ff <= seq_ff + 1'b1;
            out_kind <= 1'b0; out_lid <= '0; out_lvotes <= '0;
            out_valid <= 1'b0; out_last <= 1'b1;
            if (hit_ff) begin
               if (votes_ff[hit_slot_ff] != '1)
                  votes_ff[hit_slot_ff] <= votes_ff[hit_slot_ff] + 1'b1;
               out_present <= 1'b1; out_evf <= 1'b0; out_evid <= '0;
               out_slot <= 5'(hit_slot_ff);
            end else begin
               used_ff[tgt]  <= 1'b1;
               ids_ff[tgt]   <= cand_ff;
               votes_ff[tgt] <= VOTE_BITS'(1);
               stamp_ff[tgt] <= seq_ff;
               if (use_free) occ_ff <= occ_ff + OB'(1);
               out_present <= 1'b0;
               out_evf  <= !use_free;
               out_evid <= use_free ? '0 : ids_ff[pick_slot_ff];
               out_slot <= 5'(tgt);
            end
         end
         if (cmd.emit_list) begin
            out_kind <= 1'b1; out_present <= 1'b0; out_evf <= 1'b0;
            out_evid <= '0; out_slot <= '0;
            idx_ff <= '0; lfound_ff <= 1'b0; rem_ff <= '0;
            if (lfound_ff) begin
               out_lid <= ids_ff[lslot_ff]; out_lvotes <= votes_ff[lslot_ff];
               out_valid <= 1'b1;
               have_prev_ff <= 1'b1; prev_ff <= ids_ff[lslot_ff];
               nlist_ff <= nlist_ff + 6'd1;
               out_last <= 1'b0;
            end else begin
               out_lid <= '0; out_lvotes <= '0; out_valid <= 1'b0;
               out_last <= 1'b1;
            end
         end
         if (cmd.rsp_take) begin end
      end
   end
endmodule

>>> design/lfu_control.sv
// Controller of the LFU block: sequences scans and result hand-off.
// Depends on lfu_pkg.
module lfu_control
   import lfu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_cmd,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output lfu_cmd_type cmd,
   input  lfu_sts_type sts,
   output logic        fix_last
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SCAN = 6'b000010,
      S_COMM = 6'b000100,
      S_LSRC = 6'b001000,
      S_LEMT = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic listing_ff, listing_in;
   logic anyfound_ff, anyfound_in;
   logic last_ff, last_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign fix_last   = last_ff;

   always_comb begin
      state_in = state_ff; listing_in = listing_ff;
      anyfound_in = anyfound_ff; last_in = last_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_cmd == CMD_LIST) begin
                  cmd.start_list = 1'b1; state_in = S_LSRC;
                  listing_in = 1'b1; anyfound_in = 1'b0;
               end else begin
                  cmd.start_rec = 1'b1; state_in = S_SCAN; listing_in = 1'b0;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_COMM;
         end
         S_COMM: begin
            cmd.commit_rec = 1'b1; last_in = 1'b1; state_in = S_OUT;
         end
         S_LSRC: begin
            cmd.list_step = 1'b1;
            if (sts.scan_done) state_in = S_LEMT;
         end
         S_LEMT: begin
            // a miss after some found entries ends the list silently
            if (!sts.list_found && anyfound_ff) begin
               state_in = S_IDLE;
            end else begin
               cmd.emit_list = 1'b1; state_in = S_OUT;
               if (sts.list_found) anyfound_in = 1'b1;
               last_in = !sts.list_found || !sts.list_more;
               listing_in = sts.list_found && sts.list_more;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               cmd.rsp_take = 1'b1;
               state_in = listing_ff ? S_LSRC : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; listing_ff <= 1'b0;
         anyfound_ff <= 1'b0; last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; listing_ff <= listing_in;
         anyfound_ff <= anyfound_in; last_ff <= last_in;
      end
   end
endmodule

>>> design/lfu_oldest_slot_replacement.sv
// Top level of the LFU oldest-slot replacement block.
// Depends on lfu_pkg, lfu_control and lfu_datapath.
//
// This block keeps up to SLOTS candidate ids, each with a vote count and an
// insertion stamp. A recommend word searches the slots one per cycle, then
// commits a hit, an insertion into the lowest free slot, or an eviction of the
// least voted, oldest candidate, and then waits for the output hand-off. A
// list word emits held ids in ascending order; each entry costs a full
// serial pass over the slots, searched one slot per cycle. Listing of an
// empty set gives one word with entry_valid low. The slot limit is written
// on the csr channel while idle.
module lfu_oldest_slot_replacement
   import lfu_pkg::*;
#(
   parameter int unsigned SLOTS   = 32,
   parameter int unsigned ID_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // candidate[7:0]
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // was_present, evicted_flag, evicted_candidate,
                                    // slot_index, listed_candidate, listed_votes,
                                    // entry_valid
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data
);
   lfu_cmd_type cmd;
   lfu_sts_type sts;
   logic [CFG_BITS-1:0] frames_ff;
   logic fix_last;

   logic                 o_kind, o_pres, o_evf, o_valid, o_last;
   logic [ID_BITS-1:0]   o_evid, o_lid;
   logic [4:0]           o_slot;
   logic [VOTE_BITS-1:0] o_lv;

   // The limit may only change while no word is in flight.
   assign csr_ready = req_tready;
   always_ff @(posedge clock) begin
      if (reset) frames_ff <= CFG_BITS'(32);
      else if (csr_valid && csr_ready) frames_ff <= csr_data;
   end

   lfu_control u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .req_cmd(req_tuser),
      .rsp_tvalid, .rsp_tready, .cmd, .sts, .fix_last
   );

   lfu_datapath #(.SLOTS(SLOTS), .ID_BITS(ID_BITS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .cand(ID_BITS'(req_tdata[7:0])), .frames(frames_ff),
      .out_kind(o_kind), .out_present(o_pres), .out_evf(o_evf), .out_evid(o_evid),
      .out_slot(o_slot), .out_lid(o_lid), .out_lvotes(o_lv),
      .out_valid(o_valid), .out_last(o_last)
   );

   // The final entry of a listing is marked by the controller.
   assign rsp_tlast = o_last | fix_last;
   assign rsp_tuser = o_kind;
   assign rsp_tdata = {o_valid, o_lv, 8'(o_lid), o_slot, 8'(o_evid),
                       o_evf, o_pres};
endmodule

>>> design/lfu_checker.sv
// Port-level checker for the LFU block and its bind.
// Depends on lfu_oldest_slot_replacement.
module lfu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");
   a_rec_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("recommend answer not marked last");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a result is pending");
   a_rec_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[39:15] == '0)
      else $error("recommend answer carries list fields");
endmodule

bind lfu_oldest_slot_replacement lfu_checker u_chk (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the LFU oldest-slot replacement block.
// Depends on lfu_pkg and the lfu_oldest_slot_replacement top level only.
// A local slot model predicts every response word, which is checked in order.
module tb_top
   import lfu_pkg::*;
;

   localparam int unsigned SLOTS    = 32;
   localparam int unsigned ID_BITS  = 8;
   // Margin after the last expected word before the block is touched again.
   localparam int unsigned SETTLE   = SLOTS + 8;
   localparam int unsigned NUM_RAND = 360;

   // One expected response word, field by field.
   typedef struct packed {
      logic        kind;
      logic        was_present;
      logic        evicted_flag;
      logic [7:0]  evicted_candidate;
      logic [4:0]  slot_index;
      logic [7:0]  listed_candidate;
      logic [15:0] listed_votes;
      logic        entry_valid;
      logic        last;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // candidate[7:0]
   logic        req_tuser = 1'b0; // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // was_present, evicted_flag, evicted_candidate,
                                  // slot_index, listed_candidate, listed_votes,
                                  // entry_valid
   logic        rsp_tuser;        // kind
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data = '0;

   always #5 clock = ~clock;

   lfu_oldest_slot_replacement #(
      .SLOTS   (SLOTS),
      .ID_BITS (ID_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Local copy of the slot table, the slot limit and the stamp counter.
   logic [7:0]  held_id    [SLOTS];
   logic        held_used  [SLOTS];
   logic [15:0] held_votes [SLOTS];
   logic [31:0] held_stamp [SLOTS];
   int unsigned held_count;
   logic [31:0] stamp_next;
   logic [5:0]  frame_limit;

   rsp_word_type pending_rsp[$];
   int unsigned words_sent;
   int unsigned words_checked;
   int unsigned csr_writes;
   int unsigned lists_sent;
   int unsigned evictions_seen;
   int unsigned hits_seen;
   int unsigned mismatches;

   // Stall controls, changed by the test phases.
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned rsp_hold_cycles;

   function automatic rsp_word_type blank_word();
      rsp_word_type w;
      w.kind = CMD_RECOMMEND; w.was_present = 1'b0; w.evicted_flag = 1'b0;
      w.evicted_candidate = '0; w.slot_index = '0; w.listed_candidate = '0;
      w.listed_votes = '0; w.entry_valid = 1'b0; w.last = 1'b1;
      return w;
   endfunction

   // Append one expected word at the tail of the queue.
   function automatic void expect_word(rsp_word_type w);
      pending_rsp = {pending_rsp, w};
   endfunction

   // Recommend: hit bumps the votes, a miss fills the lowest free slot under
   // the limit, or evicts the fewest-voted, oldest candidate.
   function automatic void predict_recommend(logic [7:0] cand);
      rsp_word_type w;
      int          hit;
      int          pick;
      int unsigned limit;
      logic [31:0] stamp;
      w = blank_word();
      hit = -1;
      pick = -1;
      limit = frame_limit;
      stamp = stamp_next;
      if (limit < 1) limit = 1;
      if (limit > SLOTS) limit = SLOTS;
      if (stamp_next != '1) stamp_next++;
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && held_used[i] && held_id[i] == cand) hit = i;
      end
      if (hit >= 0) begin
         if (held_votes[hit] != '1) held_votes[hit]++;
         w.was_present = 1'b1;
         w.slot_index = hit[4:0];
         hits_seen++;
         expect_word(w);
         return;
      end
      if (held_count < limit) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (pick < 0 && !held_used[i]) pick = i;
         end
      end
      if (pick >= 0) begin
         held_count++;
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            if (held_used[i] && (pick < 0 || held_votes[i] < held_votes[pick] ||
                (held_votes[i] == held_votes[pick] && held_stamp[i] < held_stamp[pick])))
               pick = i;
         end
         w.evicted_flag = 1'b1;
         w.evicted_candidate = held_id[pick];
         evictions_seen++;
      end
      held_used[pick]  = 1'b1;
      held_id[pick]    = cand;
      held_votes[pick] = 16'd1;
      held_stamp[pick] = stamp;
      w.slot_index = pick[4:0];
      expect_word(w);
   endfunction

   // List: held ids in ascending order, at most MAX_LIST words, or one
   // empty word when nothing is held.
   function automatic void predict_list();
      rsp_word_type w;
      logic      taken [SLOTS];
      int        best;
      int        total;
      int        emitted;
      total = 0;
      emitted = 0;
      for (int i = 0; i < SLOTS; i++) begin
         taken[i] = 1'b0;
         if (held_used[i]) total++;
      end
      if (total == 0) begin
         w = blank_word();
         w.kind = CMD_LIST;
         expect_word(w);
         return;
      end
      if (total > MAX_LIST) total = MAX_LIST;
      while (emitted < total) begin
         best = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (held_used[i] && !taken[i] && (best < 0 || held_id[i] < held_id[best]))
               best = i;
         end
         taken[best] = 1'b1;
         w = blank_word();
         w.kind = CMD_LIST;
         w.listed_candidate = held_id[best];
         w.listed_votes = held_votes[best];
         w.entry_valid = 1'b1;
         w.last = (emitted == total - 1);
         expect_word(w);
         emitted++;
      end
   endfunction

   // Everything is observed at the rising edge: responses are checked first,
   // then an accepted request or csr write updates the local model.
   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.was_present       = rsp_tdata[0];
         got.evicted_flag      = rsp_tdata[1];
         got.evicted_candidate = rsp_tdata[9:2];
         got.slot_index        = rsp_tdata[14:10];
         got.listed_candidate  = rsp_tdata[22:15];
         got.listed_votes      = rsp_tdata[38:23];
         got.entry_valid       = rsp_tdata[39];
         got.kind              = rsp_tuser;
         got.last              = rsp_tlast;
         words_checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected response word kind=%0b data=%h", $realtime,
                        got.kind, rsp_tdata);
         end else begin
            want = pending_rsp.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"[%0t] response mismatch (kind pres evf evid slot lid votes",
                            " valid last)\n   expected %0b %0b %0b %0d %0d %0d %0d %0b %0b",
                            "\n   actual   %0b %0b %0b %0d %0d %0d %0d %0b %0b"},
                           $realtime, want.kind, want.was_present, want.evicted_flag,
                           want.evicted_candidate, want.slot_index, want.listed_candidate,
                           want.listed_votes, want.entry_valid, want.last,
                           got.kind, got.was_present, got.evicted_flag,
                           got.evicted_candidate, got.slot_index, got.listed_candidate,
                           got.listed_votes, got.entry_valid, got.last);
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         words_sent++;
         if (req_tuser == CMD_LIST) begin
            lists_sent++;
            predict_list();
         end else begin
            predict_recommend(req_tdata[7:0]);
         end
      end
      if (!reset && csr_valid && csr_ready) begin
         csr_writes++;
         frame_limit = csr_data;
      end
   end

   // The receiver stalls at random, or holds off completely while a long
   // hold is counted down.
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Offer one request word and wait until the block takes it. The valid
   // stays high into the next word unless that word starts with idle cycles.
   task automatic send_word(input logic cmd, input logic [7:0] cand);
      int unsigned seen;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      seen = words_sent;
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = cand;
      do @(negedge clock); while (words_sent == seen);
   endtask

   task automatic recommend(input logic [7:0] cand);
      send_word(CMD_RECOMMEND, cand);
   endtask

   task automatic list_held();
      // The candidate field is ignored here, so it carries noise.
      send_word(CMD_LIST, 8'($urandom));
   endtask

   // Wait until every expected word has come back and the block has had
   // time to return to idle.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_limit(input logic [5:0] value);
      int unsigned seen;
      wait_drained();
      seen = csr_writes;
      csr_valid = 1'b1;
      csr_data  = value;
      do @(negedge clock); while (csr_writes == seen);
      csr_valid = 1'b0;
   endtask

   // Mostly a small id pool so hits, ties and evictions are common, with
   // the full id range and list words mixed in.
   task automatic random_traffic(input int unsigned count);
      int unsigned roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 12) list_held();
         else if (roll < 72) recommend(8'($urandom_range(0, 11)));
         else recommend(8'($urandom));
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      list_held();                 // empty listing right after reset
      recommend(8'h00);
      recommend(8'hFF);
      recommend(8'h00);            // hit
      recommend(8'hAA);
      recommend(8'h55);
      recommend(8'hAA);            // hit
      list_held();
      // Limit below occupancy: misses evict, ties go to the oldest stamp.
      write_limit(6'd2);
      recommend(8'h01);            // evicts 8'hFF, fewest votes and oldest
      recommend(8'h02);            // evicts 8'h55
      recommend(8'hFF);            // evicted id returns with one vote
      list_held();
      // A zero limit behaves as one slot.
      write_limit(6'd0);
      recommend(8'h80);
      recommend(8'h7F);
      list_held();
   endtask

   task automatic test_fill_all();
      // An out of range limit clamps to every slot; fill them and list all.
      write_limit(6'd63);
      for (int i = 0; i < SLOTS + 3; i++) recommend(8'(8'd200 - i * 5));
      list_held();
   endtask

   task automatic test_random_phases();
      logic [5:0] limits [4];
      limits = '{6'd32, 6'd1, 6'd5, 6'd17};
      for (int p = 0; p < 4; p++) begin
         write_limit(limits[p]);
         unique case (p)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 54; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 54; end
            default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
         endcase
         random_traffic(NUM_RAND / 4);
      end
   endtask

   task automatic test_backpressure();
      // The receiver holds off long enough that the block must stall its
      // input while the sender keeps offering words.
      write_limit(6'd8);
      send_idle_pct = 0;
      rsp_stall_pct = 20;
      rsp_hold_cycles = 400;
      random_traffic(10);
      // Then the sender pauses until everything is back before continuing.
      wait_drained();
      random_traffic(6);
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         held_used[i] = 1'b0; held_id[i] = '0; held_votes[i] = '0; held_stamp[i] = '0;
      end
      held_count = 0;
      stamp_next = '0;
      frame_limit = 6'd32;
      words_sent = 0; words_checked = 0; csr_writes = 0; lists_sent = 0;
      evictions_seen = 0; hits_seen = 0; mismatches = 0;
      send_idle_pct = 0; rsp_stall_pct = 0; rsp_hold_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      test_fill_all();
      test_random_phases();
      test_backpressure();

      wait_drained();
      $display("Covered %0d request words (%0d lists), %0d response words, %0d hits,",
               words_sent, lists_sent, words_checked, hits_seen);
      $display("%0d evictions and %0d slot limit writes; %0d mismatches.",
               evictions_seen, csr_writes, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #100000000;
      $display("Timeout with %0d response words still expected.", pending_rsp.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> filelist.f
design/lfu_pkg.sv
design/lfu_datapath.sv
design/lfu_control.sv
design/lfu_oldest_slot_replacement.sv
design/lfu_checker.sv
verif/tb_top.sv
